[hdl/scmi_pkg.sv]
// Shared widths, codes and defaults of the step curve evaluator.
package scmi_pkg;

    localparam int STEPS_DEF     = 16;
    localparam int FRAC_BITS_DEF = 16;

    localparam int POS_W = 21;
    localparam int VAL_W = 16;
    localparam int IDX_W = 4;

    // slope magnitude and divisor widths of the harmonic-mean divide
    localparam int SLOPE_W = 17;
    localparam int DEN_W   = 17;

    localparam logic [VAL_W-1:0] ENTRY_RESET = 16'h8000;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH    = 1'b1;

endpackage

[hdl/step_curve_monotone_interp.sv]
// Step curve evaluator: step table, monotone cubic and stepped evaluation.
//
// A request is taken at a rising edge with start high and busy low. A write
// request stores one step value and leaves busy low, so writes may follow
// every cycle while busy is low. An evaluate request reads four table
// entries through the single read port of the table RAM, one per cycle, so
// busy stays high after it to keep the reads of successive evaluations
// apart. Each evaluation gives one result, shown on curve_value for exactly
// one cycle with done high. done rises after the intake stages, the table
// reads, the slope dividers and the weighted sum. Results leave in request
// order and cannot be stalled. Write requests give no result. Slopes use the
// Fritsch-Butland harmonic mean, computed by two pipelined dividers. Table
// entries never written read as one half. The user must write configuration
// only while no evaluation is in flight; the block does not enforce this.
module step_curve_monotone_interp
    import scmi_pkg::*;
#(
    parameter int STEPS     = STEPS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  command,
    input  logic [IDX_W-1:0]      step_index,
    input  logic [VAL_W-1:0]      entry_value,
    input  logic [POS_W-1:0]      position,
    output logic                  done,
    output logic [VAL_W-1:0]      curve_value,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW  = $clog2(STEPS);
    localparam int XW  = ((POS_W > FRAC_BITS) ? POS_W : FRAC_BITS + 1) + 2;
    localparam int MW  = XW - FRAC_BITS;
    localparam int SH  = MW;
    localparam int RW  = MW + 1;
    localparam int CW  = XW + 7;
    localparam int GW  = MW + 8;
    localparam int HW  = 36;
    localparam int PW  = 56;
    localparam int NW  = SLOPE_W + DEN_W;

    localparam logic [XW-1:0] ONE_X   = XW'(1) << FRAC_BITS;
    localparam logic [XW-1:0] HALF_X  = XW'(1) << (FRAC_BITS - 1);
    localparam logic [CW-1:0] LAST_X  = CW'(STEPS) << FRAC_BITS;
    localparam logic [RW-1:0] RECIP   = RW'((64'd1 << SH) / STEPS);
    localparam logic signed [GW-1:0] TWO_G   = GW'(2);
    localparam logic signed [GW-1:0] STEPS_G = GW'(STEPS);
    localparam logic signed [HW-1:0] ONE_Q32 = HW'(1) << 32;
    localparam logic signed [PW-1:0] RND_Q32 = PW'(1) << 31;

    typedef struct packed {
        logic signed [HW-1:0] h00;
        logic signed [HW-1:0] h10;
        logic signed [HW-1:0] h01;
        logic signed [HW-1:0] h11;
        logic [VAL_W-1:0]     y1;
        logic [VAL_W-1:0]     y2;
        logic [1:0]           neg;
        logic                 direct;
    } side_t;

    // ---------------- configuration registers ----------------
    logic loop_mode_reg;
    logic smooth_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loop_mode_reg <= 1'b1;
            smooth_reg    <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_LOOP_MODE: loop_mode_reg <= cfg_data[0];
                CFG_SMOOTH:    smooth_reg    <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // ---------------- request intake ----------------
    logic       accept;
    logic [1:0] busy_cnt_reg;
    logic [1:0] busy_cnt_next;

    assign busy   = (busy_cnt_reg != 2'd0);
    assign accept = start && !busy;

    always_comb
    begin
        busy_cnt_next = busy_cnt_reg;
        if (accept && (command == CMD_EVAL))
        begin
            busy_cnt_next = 2'd3;
        end
        else if (busy_cnt_reg != 2'd0)
        begin
            busy_cnt_next = busy_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_cnt_reg <= 2'd0;
        end
        else
        begin
            busy_cnt_reg <= busy_cnt_next;
        end
    end

    // Shift the position half a step down (and one step up to stay
    // non-negative); m is the step index just above the sample point.
    logic [XW-1:0]        xs;
    logic [XW-1:0]        pos_x;
    logic [FRAC_BITS+15:0] frac_x;
    logic [MW-1:0]        m_in;
    logic                 direct_in;

    always_comb
    begin
        pos_x  = XW'(position);
        xs     = pos_x + ONE_X - HALF_X;
        frac_x = {xs[FRAC_BITS-1:0], 16'b0};
        if (smooth_reg)
        begin
            m_in      = MW'(xs >> FRAC_BITS);
            direct_in = !loop_mode_reg && ((xs <= ONE_X) || (CW'(xs) >= LAST_X));
        end
        else
        begin
            m_in      = MW'((pos_x >> FRAC_BITS) + XW'(1));
            direct_in = 1'b1;
        end
    end

    // P1: request registered
    logic             p1_valid_reg;
    logic             p1_cmd_reg;
    logic [IDX_W-1:0] p1_idx_reg;
    logic [VAL_W-1:0] p1_val_reg;
    logic [MW-1:0]    p1_m_reg;
    logic [15:0]      p1_t_reg;
    logic             p1_direct_reg;

    // P2: reciprocal product for the modulo
    logic             p2_valid_reg;
    logic             p2_cmd_reg;
    logic [IDX_W-1:0] p2_idx_reg;
    logic [VAL_W-1:0] p2_val_reg;
    logic [MW-1:0]    p2_m_reg;
    logic [15:0]      p2_t_reg;
    logic             p2_direct_reg;
    logic [MW+RW-1:0] p2_prod_reg;

    // P3: base index modulo STEPS
    logic             p3_valid_reg;
    logic             p3_cmd_reg;
    logic [IDX_W-1:0] p3_idx_reg;
    logic [VAL_W-1:0] p3_val_reg;
    logic [MW-1:0]    p3_m_reg;
    logic [15:0]      p3_t_reg;
    logic             p3_direct_reg;
    logic [AW-1:0]    p3_r_reg;

    logic [GW-1:0] qs;
    logic [GW-1:0] r0;
    logic [GW-1:0] r_fix;

    always_comb
    begin
        qs    = GW'(p2_prod_reg[MW+RW-1:SH]) * GW'(STEPS);
        r0    = GW'(p2_m_reg) - qs;
        r_fix = (r0 >= GW'(STEPS)) ? r0 - GW'(STEPS) : r0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= accept;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_cmd_reg    <= command;
        p1_idx_reg    <= step_index;
        p1_val_reg    <= entry_value;
        p1_m_reg      <= m_in;
        p1_t_reg      <= frac_x[FRAC_BITS+15:FRAC_BITS];
        p1_direct_reg <= direct_in;

        p2_cmd_reg    <= p1_cmd_reg;
        p2_idx_reg    <= p1_idx_reg;
        p2_val_reg    <= p1_val_reg;
        p2_m_reg      <= p1_m_reg;
        p2_t_reg      <= p1_t_reg;
        p2_direct_reg <= p1_direct_reg;
        p2_prod_reg   <= (MW+RW)'(p1_m_reg) * (MW+RW)'(RECIP);

        p3_cmd_reg    <= p2_cmd_reg;
        p3_idx_reg    <= p2_idx_reg;
        p3_val_reg    <= p2_val_reg;
        p3_m_reg      <= p2_m_reg;
        p3_t_reg      <= p2_t_reg;
        p3_direct_reg <= p2_direct_reg;
        p3_r_reg      <= AW'(r_fix);
    end

    // ---------------- table and read sequencer ----------------
    logic             tbl_we;
    logic [AW-1:0]    tbl_waddr;
    logic [AW-1:0]    tbl_raddr;
    logic [VAL_W-1:0] tbl_rdata;
    logic [STEPS-1:0] entry_ok_reg;
    logic             p3_eval;

    // writes take effect in request order, between evaluation reads
    assign tbl_we    = p3_valid_reg && (p3_cmd_reg == CMD_WRITE)
                       && ({3'b0, p3_idx_reg} < 7'(STEPS));
    assign tbl_waddr = AW'(p3_idx_reg);
    assign p3_eval   = p3_valid_reg && (p3_cmd_reg == CMD_EVAL);

    scmi_ram #(
        .WIDTH (VAL_W),
        .DEPTH (STEPS)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (p3_val_reg),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    logic          seq_live_reg;
    logic [1:0]    seq_cnt_reg;
    logic [AW-1:0] seq_r_reg;
    logic [MW-1:0] seq_m_reg;
    logic [15:0]   seq_t_reg;
    logic          seq_direct_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_live_reg <= 1'b0;
            seq_cnt_reg  <= 2'd0;
            entry_ok_reg <= '0;
        end
        else
        begin
            if (p3_eval)
            begin
                seq_live_reg <= 1'b1;
                seq_cnt_reg  <= 2'd0;
            end
            else if (seq_live_reg)
            begin
                seq_live_reg <= (seq_cnt_reg != 2'd3);
                seq_cnt_reg  <= seq_cnt_reg + 2'd1;
            end
            if (tbl_we)
            begin
                entry_ok_reg[tbl_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (p3_eval)
        begin
            seq_r_reg      <= p3_r_reg;
            seq_m_reg      <= p3_m_reg;
            seq_t_reg      <= p3_t_reg;
            seq_direct_reg <= p3_direct_reg;
        end
    end

    // entry for slot i is m-2+i, wrapped in loop mode, clamped otherwise
    logic signed [GW-1:0] a_raw;
    logic signed [GW-1:0] a_fix;

    always_comb
    begin
        if (loop_mode_reg)
        begin
            a_raw = $signed(GW'(seq_r_reg)) + $signed(GW'(seq_cnt_reg)) - TWO_G;
            if (a_raw < 0)
            begin
                a_fix = a_raw + STEPS_G;
            end
            else if (a_raw >= STEPS_G)
            begin
                a_fix = a_raw - STEPS_G;
            end
            else
            begin
                a_fix = a_raw;
            end
        end
        else
        begin
            a_raw = $signed(GW'(seq_m_reg)) + $signed(GW'(seq_cnt_reg)) - TWO_G;
            if (a_raw < 0)
            begin
                a_fix = '0;
            end
            else if (a_raw >= STEPS_G)
            begin
                a_fix = STEPS_G - GW'(1);
            end
            else
            begin
                a_fix = a_raw;
            end
        end
        tbl_raddr = AW'(a_fix);
    end

    logic        rd_live_reg;
    logic [1:0]  rd_slot_reg;
    logic        rd_ok_reg;
    logic [15:0] rd_t_reg;
    logic        rd_direct_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_live_reg <= 1'b0;
        end
        else
        begin
            rd_live_reg <= seq_live_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_slot_reg   <= seq_cnt_reg;
        rd_ok_reg     <= entry_ok_reg[tbl_raddr];
        rd_t_reg      <= seq_t_reg;
        rd_direct_reg <= seq_direct_reg;
    end

    // S0: the four neighbors y[k-1..k+2] gathered
    logic [VAL_W-1:0] y_reg [0:3];
    logic             s0_valid_reg;
    logic [15:0]      s0_t_reg;
    logic             s0_direct_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= rd_live_reg && (rd_slot_reg == 2'd3);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_live_reg)
        begin
            y_reg[rd_slot_reg] <= rd_ok_reg ? tbl_rdata : ENTRY_RESET;
        end
        s0_t_reg      <= rd_t_reg;
        s0_direct_reg <= rd_direct_reg;
    end

    // ---------------- slopes ----------------
    logic                s1_valid_reg;
    logic                s2_valid_reg;
    logic [31:0]         s1_t2_reg;
    logic [15:0]         s1_t_reg;
    logic [VAL_W-1:0]    s1_y1_reg;
    logic [VAL_W-1:0]    s1_y2_reg;
    logic                s1_direct_reg;
    logic [31:0]         s2_t2_reg;
    logic [31:0]         s2_t3_reg;
    logic [15:0]         s2_t_reg;
    logic [VAL_W-1:0]    s2_y1_reg;
    logic [VAL_W-1:0]    s2_y2_reg;
    logic                s2_direct_reg;
    logic [1:0]          s1_neg_reg;
    logic [1:0]          s2_neg_reg;
    logic [1:0]          div_valid;
    logic [SLOPE_W-1:0]  div_quo [0:1];
    logic [47:0]         t3_full;

    assign t3_full = 48'(s1_t2_reg) * 48'(s1_t_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_t2_reg     <= 32'(s0_t_reg) * 32'(s0_t_reg);
        s1_t_reg      <= s0_t_reg;
        s1_y1_reg     <= y_reg[1];
        s1_y2_reg     <= y_reg[2];
        s1_direct_reg <= s0_direct_reg;
        s2_t2_reg     <= s1_t2_reg;
        s2_t3_reg     <= t3_full[47:16];
        s2_t_reg      <= s1_t_reg;
        s2_y1_reg     <= s1_y1_reg;
        s2_y2_reg     <= s1_y2_reg;
        s2_direct_reg <= s1_direct_reg;
        s2_neg_reg    <= s1_neg_reg;
    end

    genvar g;
    generate
        for (g = 0; g < 2; g++)
        begin : g_slope
            logic signed [16:0] d0;
            logic signed [16:0] d1;
            logic [15:0]        mag0;
            logic [15:0]        mag1;
            logic               flat;
            logic [31:0]        s1_prod_reg;
            logic [DEN_W-1:0]   s1_den_reg;
            logic               s1_zero_reg;
            logic [NW-1:0]      s2_num_reg;
            logic [DEN_W-1:0]   s2_den_reg;

            always_comb
            begin
                d0   = $signed({1'b0, y_reg[g+1]}) - $signed({1'b0, y_reg[g]});
                d1   = $signed({1'b0, y_reg[g+2]}) - $signed({1'b0, y_reg[g+1]});
                mag0 = d0[16] ? 16'(-d0) : 16'(d0);
                mag1 = d1[16] ? 16'(-d1) : 16'(d1);
                // zero slope at a peak, a valley or a flat side
                flat = (d0 == 0) || (d1 == 0) || (d0[16] != d1[16]);
            end

            always_ff @(posedge clk)
            begin
                s1_prod_reg   <= 32'(mag0) * 32'(mag1);
                s1_den_reg    <= DEN_W'(mag0) + DEN_W'(mag1);
                s1_zero_reg   <= flat;
                s1_neg_reg[g] <= d0[16];
                // 2ab plus half the divisor rounds the quotient to nearest
                s2_num_reg    <= s1_zero_reg ? '0
                                 : NW'({s1_prod_reg, 1'b0}) + NW'(s1_den_reg >> 1);
                s2_den_reg    <= s1_zero_reg ? DEN_W'(1) : s1_den_reg;
            end

            scmi_div #(
                .QW (SLOPE_W),
                .DW (DEN_W)
            ) u_div (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (s2_valid_reg),
                .num       (s2_num_reg),
                .den       (s2_den_reg),
                .out_valid (div_valid[g]),
                .quo       (div_quo[g])
            );
        end
    endgenerate

    // ---------------- Hermite basis, held beside the dividers ----------------
    side_t side_next;
    side_t side_reg [0:SLOPE_W-1];
    logic signed [HW-1:0] tt2;
    logic signed [HW-1:0] tt3;
    logic signed [HW-1:0] tt1;

    always_comb
    begin
        tt2 = $signed(HW'(s2_t2_reg));
        tt3 = $signed(HW'(s2_t3_reg));
        tt1 = $signed(HW'(s2_t_reg)) <<< 16;
        side_next.h00    = (tt3 <<< 1) - (tt2 + (tt2 <<< 1)) + ONE_Q32;
        side_next.h10    = tt3 - (tt2 <<< 1) + tt1;
        side_next.h01    = (tt2 + (tt2 <<< 1)) - (tt3 <<< 1);
        side_next.h11    = tt3 - tt2;
        side_next.y1     = s2_y1_reg;
        side_next.y2     = s2_y2_reg;
        side_next.neg    = s2_neg_reg;
        side_next.direct = s2_direct_reg;
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_next;
        for (int i = 1; i < SLOPE_W; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    // ---------------- weighted sum and output ----------------
    side_t                 sd;
    logic signed [17:0]    sk0;
    logic signed [17:0]    sk1;

    assign sd  = side_reg[SLOPE_W-1];
    assign sk0 = sd.neg[0] ? -$signed({1'b0, div_quo[0]}) : $signed({1'b0, div_quo[0]});
    assign sk1 = sd.neg[1] ? -$signed({1'b0, div_quo[1]}) : $signed({1'b0, div_quo[1]});

    logic                  m_valid_reg;
    logic                  a_valid_reg;
    logic                  f_valid_reg;
    logic signed [PW-1:0]  m00_reg;
    logic signed [PW-1:0]  m10_reg;
    logic signed [PW-1:0]  m01_reg;
    logic signed [PW-1:0]  m11_reg;
    logic signed [PW-1:0]  sa_reg;
    logic signed [PW-1:0]  sb_reg;
    logic signed [PW-1:0]  sum_reg;
    logic [VAL_W-1:0]      m_y1_reg;
    logic [VAL_W-1:0]      a_y1_reg;
    logic [VAL_W-1:0]      f_y1_reg;
    logic                  m_direct_reg;
    logic                  a_direct_reg;
    logic                  f_direct_reg;
    logic signed [PW-1:0]  rnd;
    logic [VAL_W-1:0]      result;
    logic                  done_reg;
    logic [VAL_W-1:0]      curve_value_reg;

    always_comb
    begin
        rnd = (sum_reg + RND_Q32) >>> 32;
        if (f_direct_reg)
        begin
            result = f_y1_reg;
        end
        else if (sum_reg <= 0)
        begin
            result = '0;
        end
        else if (rnd > PW'(65535))
        begin
            result = 16'hFFFF;
        end
        else
        begin
            result = VAL_W'(rnd);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            a_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            m_valid_reg <= div_valid[0];
            a_valid_reg <= m_valid_reg;
            f_valid_reg <= a_valid_reg;
            done_reg    <= f_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m00_reg      <= sd.h00 * $signed({1'b0, sd.y1});
        m10_reg      <= sd.h10 * sk0;
        m01_reg      <= sd.h01 * $signed({1'b0, sd.y2});
        m11_reg      <= sd.h11 * sk1;
        m_y1_reg     <= sd.y1;
        m_direct_reg <= sd.direct;

        sa_reg       <= m00_reg + m10_reg;
        sb_reg       <= m01_reg + m11_reg;
        a_y1_reg     <= m_y1_reg;
        a_direct_reg <= m_direct_reg;

        sum_reg      <= sa_reg + sb_reg;
        f_y1_reg     <= a_y1_reg;
        f_direct_reg <= a_direct_reg;

        curve_value_reg <= result;
    end

    assign done        = done_reg;
    assign curve_value = curve_value_reg;

endmodule

[hdl/scmi_ram.sv]
// Generic single-port-write, registered-read RAM.
module scmi_ram
    import scmi_pkg::*;
#(
    parameter int WIDTH = VAL_W,
    parameter int DEPTH = STEPS_DEF
)(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/scmi_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
module scmi_div
    import scmi_pkg::*;
#(
    parameter int QW = SLOPE_W,
    parameter int DW = DEN_W
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [QW+DW-1:0] num,
    input  logic [DW-1:0]    den,
    output logic             out_valid,
    output logic [QW-1:0]    quo
);

    // the upper DW bits of num must already be below den
    logic [DW-1:0] rem_reg [1:QW];
    logic [QW-1:0] low_reg [1:QW];
    logic [QW-1:0] q_reg   [1:QW];
    logic [DW-1:0] den_reg [1:QW];
    logic          v_reg   [1:QW];

    genvar j;
    generate
        for (j = 1; j <= QW; j++)
        begin : g_stage
            logic [DW-1:0] rem_in;
            logic [DW-1:0] den_in;
            logic [QW-1:0] low_in;
            logic [QW-1:0] q_in;
            logic          v_in;
            logic [DW:0]   trial;
            logic          fits;

            if (j == 1)
            begin : g_first
                assign rem_in = num[QW+DW-1:QW];
                assign low_in = num[QW-1:0];
                assign q_in   = '0;
                assign den_in = den;
                assign v_in   = in_valid;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[j-1];
                assign low_in = low_reg[j-1];
                assign q_in   = q_reg[j-1];
                assign den_in = den_reg[j-1];
                assign v_in   = v_reg[j-1];
            end

            assign trial = {rem_in, low_in[QW-1]};
            assign fits  = (trial >= {1'b0, den_in});

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[j] <= 1'b0;
                end
                else
                begin
                    v_reg[j] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg[j] <= fits ? DW'(trial - {1'b0, den_in}) : DW'(trial);
                low_reg[j] <= {low_in[QW-2:0], 1'b0};
                q_reg[j]   <= {q_in[QW-2:0], fits};
                den_reg[j] <= den_in;
            end
        end
    endgenerate

    assign out_valid = v_reg[QW];
    assign quo       = q_reg[QW];

endmodule
